### rtl/core/flpte_pkg.sv
// ----------------------------------------------------------------------------
// flpte_pkg
// Shared types and constants of the four-level page table engine.
// ----------------------------------------------------------------------------
package flpte_pkg;

   localparam int TABLE_PAGES_DEF = 64;
   localparam int IDX_W           = 9;
   localparam int ENTRIES         = 512;
   localparam int VA_W            = 48;
   localparam int PA_W            = 52;
   localparam int ENTRY_W         = 64;
   localparam int FRAME_LSB       = 12;
   localparam int PW_W            = 6;
   localparam int CSR_AW          = 3;
   localparam int CSR_DW          = 32;

   localparam logic [PW_W-1:0]      PHYS_WIDTH_RST = 6'd52;
   localparam logic [FRAME_LSB-1:0] UPPER_FLAGS    = 12'h007;
   localparam logic [FRAME_LSB-1:0] OFFSET_MASK    = 12'hfff;

   typedef enum logic [1:0] {
      ACT_MAP   = 2'd0,
      ACT_UNMAP = 2'd1,
      ACT_XLATE = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STAT_DONE   = 2'd0,
      STAT_ABSENT = 2'd1,
      STAT_NOPAGE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_CLEAR,
      ST_LINK,
      ST_RESP
   } state_type;

   typedef enum logic [0:0] {
      REG_PHYS_WIDTH = 1'b0
   } csr_reg_type;

endpackage

### rtl/core/flpte_req_if.sv
// ----------------------------------------------------------------------------
// flpte_req_if
// Request channel: one word per map, unmap or translate request.
// ----------------------------------------------------------------------------
interface flpte_req_if
   import flpte_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [1:0]          action;
   logic [VA_W-1:0]     virt_addr;
   logic [PA_W-1:0]     phys_in;
   logic [ENTRY_W-1:0]  entry_flags;
   logic                release_frame;

   modport source (output valid, action, virt_addr, phys_in, entry_flags, release_frame,
                   input ready);
   modport sink (input valid, action, virt_addr, phys_in, entry_flags, release_frame,
                 output ready);
endinterface

### rtl/core/flpte_rsp_if.sv
// ----------------------------------------------------------------------------
// flpte_rsp_if
// Response channel: one word per request.
// ----------------------------------------------------------------------------
interface flpte_rsp_if
   import flpte_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [1:0]       status;
   logic [PA_W-1:0]  result_addr;
   logic             release_valid;

   modport source (output valid, status, result_addr, release_valid, input ready);
   modport sink (input valid, status, result_addr, release_valid, output ready);
endinterface

### rtl/core/four_level_page_table_engine_core.sv
// ----------------------------------------------------------------------------
// four_level_page_table_engine_core
// Four-level page table walker with map, unmap and translate over an internal
// table page memory and a bump allocator for new table pages.
// ----------------------------------------------------------------------------
// each level is walked in a read state, then a check state, on the table memory;
//   a full walk covers 4 levels between accept and response, fewer on a miss
// each newly allocated table has its 512 entries cleared, then a link write
// one request at a time: a new word is taken only after the response is taken
// reset: synchronous; a pass then clears the root table entry by entry, no request
//   is taken meanwhile (register writes are taken as usual)
module four_level_page_table_engine_core
   import flpte_pkg::*;
#(
   parameter int TABLE_PAGES = TABLE_PAGES_DEF
)
(
   input  logic               clock,
   input  logic               reset,
   flpte_req_if.sink          req_ch,
   flpte_rsp_if.source        rsp_ch,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [CSR_AW-1:0]  paddr,
   input  logic [CSR_DW-1:0]  pwdata,
   output logic [CSR_DW-1:0]  prdata,
   output logic               pready
);

   localparam int PG_W = $clog2(TABLE_PAGES);
   localparam int NP_W = $clog2(TABLE_PAGES + 1);
   localparam int AW   = PG_W + IDX_W;
   localparam int FN_W = PA_W - FRAME_LSB;
   localparam logic [FN_W-1:0] TP_FN   = FN_W'(TABLE_PAGES);
   localparam logic [NP_W-1:0] TP_NP   = NP_W'(TABLE_PAGES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   state_type           state_ff, state_in;
   logic [1:0]          level_ff, level_in;
   logic [PG_W-1:0]     page_ff, page_in;
   logic [AW-1:0]       addr_ff, addr_in;
   logic [IDX_W-1:0]    cnt_ff, cnt_in;
   logic [PG_W-1:0]     clr_page_ff, clr_page_in;
   logic [NP_W-1:0]     next_page_ff, next_page_in;
   action_type          act_ff, act_in;
   logic [VA_W-1:0]     va_ff, va_in;
   logic [PA_W-1:0]     pa_ff, pa_in;
   logic [ENTRY_W-1:0]  flags_ff, flags_in;
   logic                rel_ff, rel_in;
   status_type          status_ff, status_in;
   logic [PA_W-1:0]     res_addr_ff, res_addr_in;
   logic                rel_valid_ff, rel_valid_in;

   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [ENTRY_W-1:0]  wr_data;
   logic [AW-1:0]       rd_addr;
   logic [ENTRY_W-1:0]  rd_data;
   logic [IDX_W-1:0]    level_idx;
   logic [PW_W-1:0]     phys_width;
   logic [PA_W-1:0]     pw_mask;
   logic                req_fire;
   logic                present;
   logic                full;
   logic                is_leaf;
   logic                cnt_last;

   flpte_store #(
      .TABLE_PAGES (TABLE_PAGES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   flpte_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .phys_width (phys_width)
   );

   assign req_ch.ready         = (state_ff == ST_IDLE);
   assign rsp_ch.valid         = (state_ff == ST_RESP);
   assign rsp_ch.status        = status_ff;
   assign rsp_ch.result_addr   = res_addr_ff;
   assign rsp_ch.release_valid = rel_valid_ff;

   assign req_fire = req_ch.valid && (state_ff == ST_IDLE);
   assign is_leaf  = (level_ff == 2'd3);
   assign cnt_last = (cnt_ff == LAST_IDX);
   assign full     = (next_page_ff >= TP_NP);
   assign present  = rd_data[0] && (rd_data[PA_W-1:FRAME_LSB] < TP_FN);

   always_comb begin
      case (level_ff)
         2'd0:    level_idx = va_ff[47:39];
         2'd1:    level_idx = va_ff[38:30];
         2'd2:    level_idx = va_ff[29:21];
         default: level_idx = va_ff[20:12];
      endcase
   end

   assign rd_addr = {page_ff, level_idx};

   // translate mask: bits 51..12 below phys_width
   always_comb begin
      pw_mask = '0;
      for (int i = FRAME_LSB; i < PA_W; i++) begin
         pw_mask[i] = (i < int'(phys_width));
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (cnt_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               state_in = (action_type'(req_ch.action) == ACT_NONE) ? ST_RESP : ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (is_leaf) begin
               state_in = ST_RESP;
            end else if (present) begin
               state_in = ST_READ;
            end else if (act_ff != ACT_MAP || full) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_CLEAR;
            end
         end
         ST_CLEAR: begin
            if (cnt_last) begin
               state_in = ST_LINK;
            end
         end
         ST_LINK: begin
            state_in = ST_READ;
         end
         ST_RESP: begin
            if (rsp_ch.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      level_in     = level_ff;
      page_in      = page_ff;
      addr_in      = addr_ff;
      cnt_in       = cnt_ff;
      clr_page_in  = clr_page_ff;
      next_page_in = next_page_ff;
      act_in       = act_ff;
      va_in        = va_ff;
      pa_in        = pa_ff;
      flags_in     = flags_ff;
      rel_in       = rel_ff;
      status_in    = status_ff;
      res_addr_in  = res_addr_ff;
      rel_valid_in = rel_valid_ff;
      wr_en        = 1'b0;
      wr_addr      = addr_ff;
      wr_data      = '0;
      unique case (state_ff)
         ST_INIT, ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = {clr_page_ff, cnt_ff};
            cnt_in  = cnt_ff + 1'b1;
         end
         ST_IDLE: begin
            if (req_fire) begin
               act_in       = action_type'(req_ch.action);
               va_in        = req_ch.virt_addr;
               pa_in        = req_ch.phys_in;
               flags_in     = req_ch.entry_flags;
               rel_in       = req_ch.release_frame;
               level_in     = 2'd0;
               page_in      = '0;
               status_in    = STAT_DONE;
               res_addr_in  = '0;
               rel_valid_in = 1'b0;
            end
         end
         ST_READ: begin
            addr_in = rd_addr;
         end
         ST_CHECK: begin
            if (!is_leaf) begin
               if (present) begin
                  page_in  = rd_data[FRAME_LSB +: PG_W];
                  level_in = level_ff + 1'b1;
               end else if (act_ff != ACT_MAP) begin
                  status_in = STAT_ABSENT;
               end else if (full) begin
                  status_in = STAT_NOPAGE;
               end else begin
                  clr_page_in  = next_page_ff[PG_W-1:0];
                  next_page_in = next_page_ff + 1'b1;
                  cnt_in       = '0;
               end
            end else begin
               case (act_ff)
                  ACT_MAP: begin
                     wr_en   = 1'b1;
                     wr_data = {{(ENTRY_W-PA_W){1'b0}}, pa_ff} | flags_ff;
                  end
                  ACT_UNMAP: begin
                     wr_en = 1'b1;
                     if (rel_ff) begin
                        res_addr_in  = {rd_data[PA_W-1:FRAME_LSB], {FRAME_LSB{1'b0}}};
                        rel_valid_in = 1'b1;
                     end
                  end
                  ACT_XLATE: begin
                     res_addr_in = (rd_data[PA_W-1:0] & pw_mask)
                                   | {{FN_W{1'b0}}, va_ff[FRAME_LSB-1:0] & OFFSET_MASK};
                  end
                  default: begin
                     res_addr_in = '0;
                  end
               endcase
            end
         end
         ST_LINK: begin
            wr_en    = 1'b1;
            wr_data  = {{(ENTRY_W-PG_W-FRAME_LSB){1'b0}}, clr_page_ff, UPPER_FLAGS};
            page_in  = clr_page_ff;
            level_in = level_ff + 1'b1;
         end
         ST_RESP: begin
            wr_en = 1'b0;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cnt_ff       <= '0;
         clr_page_ff  <= '0;
         next_page_ff <= NP_W'(1);
         level_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         clr_page_ff  <= clr_page_in;
         next_page_ff <= next_page_in;
         level_ff     <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff      <= page_in;
      addr_ff      <= addr_in;
      act_ff       <= act_in;
      va_ff        <= va_in;
      pa_ff        <= pa_in;
      flags_ff     <= flags_in;
      rel_ff       <= rel_in;
      status_ff    <= status_in;
      res_addr_ff  <= res_addr_in;
      rel_valid_ff <= rel_valid_in;
   end

endmodule

### rtl/core/flpte_store.sv
// ----------------------------------------------------------------------------
// flpte_store
// Table page memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module flpte_store
   import flpte_pkg::*;
#(
   parameter int TABLE_PAGES = TABLE_PAGES_DEF
)
(
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [$clog2(TABLE_PAGES)+IDX_W-1:0]       wr_addr,
   input  logic [ENTRY_W-1:0]                         wr_data,
   input  logic [$clog2(TABLE_PAGES)+IDX_W-1:0]       rd_addr,
   output logic [ENTRY_W-1:0]                         rd_data
);

   localparam int DEPTH = TABLE_PAGES * ENTRIES;

   logic [ENTRY_W-1:0] mem [DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/flpte_csr.sv
// ----------------------------------------------------------------------------
// flpte_csr
// APB-style register block holding the physical address width.
// ----------------------------------------------------------------------------
module flpte_csr
   import flpte_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [CSR_AW-1:0]  paddr,
   input  logic [CSR_DW-1:0]  pwdata,
   output logic [CSR_DW-1:0]  prdata,
   output logic               pready,
   output logic [PW_W-1:0]    phys_width
);

   logic [PW_W-1:0] phys_width_ff;
   logic [PW_W-1:0] phys_width_in;
   logic            sel_pw;

   assign sel_pw = (paddr[CSR_AW-1] == REG_PHYS_WIDTH);
   assign pready = 1'b1;

   always_comb begin
      phys_width_in = phys_width_ff;
      if (psel && penable && pwrite && sel_pw) begin
         phys_width_in = pwdata[PW_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phys_width_ff <= PHYS_WIDTH_RST;
      end else begin
         phys_width_ff <= phys_width_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (sel_pw) begin
         prdata = {{(CSR_DW-PW_W){1'b0}}, phys_width_ff};
      end
   end

   assign phys_width = phys_width_ff;

endmodule
